>>> design/rsv_pkg.sv
// Shared types and constants for the running sample variance block.
`default_nettype none
package rsv_pkg;

  localparam int unsigned COL_W    = 10;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned M2_W     = 64;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned DELTA_W  = SAMPLE_W + 1;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 16'd65535;

  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_MEAN = 7'd33;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_VAR  = 7'd64;

  localparam int unsigned MUL_CNT_W = 6;
  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = 6'd33;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
    logic [M2_W-1:0]      dividend;
    logic [COUNT_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [DELTA_W-1:0] mcand;
    logic [DELTA_W-1:0] mplier;
  } mul_req_t;

endpackage
`default_nettype wire

>>> design/rsv_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
`default_nettype none
module rsv_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rsv_pkg::div_req_t          req,
  output logic                            done,
  output logic [rsv_pkg::M2_W-1:0]        quotient
);

  logic [rsv_pkg::M2_W-1:0]      dvd_r, dvd_nxt;
  logic [rsv_pkg::COUNT_W:0]     rem_r, rem_nxt;
  logic [rsv_pkg::COUNT_W-1:0]   dsr_r, dsr_nxt;
  logic [rsv_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rsv_pkg::COUNT_W:0]     rem_sh;
  logic                          ge;

  always_comb begin
    rem_sh   = {rem_r[rsv_pkg::COUNT_W-1:0], dvd_r[rsv_pkg::M2_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      dvd_nxt = {dvd_r[rsv_pkg::M2_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == {{(rsv_pkg::DIV_CNT_W-1){1'b0}}, 1'b1}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

>>> design/rsv_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
`default_nettype none
module rsv_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rsv_pkg::mul_req_t     req,
  output logic                       done,
  output logic [rsv_pkg::M2_W-1:0]   product
);

  logic [rsv_pkg::DELTA_W-1:0]   mc_r, mc_nxt;
  logic [rsv_pkg::DELTA_W:0]     hi_r, hi_nxt;
  logic [rsv_pkg::DELTA_W-1:0]   lo_r, lo_nxt;
  logic [rsv_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [rsv_pkg::DELTA_W:0]     sum;

  always_comb begin
    sum      = hi_r + (lo_r[0] ? {1'b0, mc_r} : '0);
    mc_nxt   = mc_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      mc_nxt   = req.mcand;
      hi_nxt   = '0;
      lo_nxt   = req.mplier;
      cnt_nxt  = rsv_pkg::MUL_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = {1'b0, sum[rsv_pkg::DELTA_W:1]};
      lo_nxt  = {sum[0], lo_r[rsv_pkg::DELTA_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == {{(rsv_pkg::MUL_CNT_W-1){1'b0}}, 1'b1}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mc_r <= mc_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done    = done_r;
  assign product = {hi_r[rsv_pkg::M2_W-rsv_pkg::DELTA_W-1:0], lo_r};

endmodule
`default_nettype wire

>>> design/running_sample_variance.sv
// Top level: Welford running mean and M2 per column run, variance on the last sample.
//
// Samples are signed Q16.16; each updates a running count, mean and sum of squared
// deviations (M2). A sample marked last also yields one result: the column, the count
// and M2 / (count - 1) in unsigned Q32.32, with status 1 for a one-sample run and
// status 2 when M2 saturated or samples were dropped at a full count. Items are taken
// one at a time. An ordinary sample passes through the shared bit-serial divider for
// delta / n and the mean update, then the residual, then the bit-serial multiplier for
// the M2 increment. A last sample then also uses the same divider for the variance,
// plus any wait for the output register to free. A sample arriving at a full count is
// dropped without a divide. A finished result waits in the output register while the
// next samples are processed.
`default_nettype none
module running_sample_variance (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [rsv_pkg::COL_W-1:0]       in_column_index,
  input  wire logic signed [rsv_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic                            in_last_sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rsv_pkg::COL_W-1:0]            out_result_column,
  output logic [rsv_pkg::M2_W-1:0]             out_variance,
  output logic [rsv_pkg::COUNT_W-1:0]          out_sample_count,
  output logic [rsv_pkg::STAT_W-1:0]           out_status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RES  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_VDIV = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  logic [rsv_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [rsv_pkg::SAMPLE_W-1:0]     mean_r, mean_nxt;
  logic [rsv_pkg::M2_W-1:0]         m2_r, m2_nxt;
  logic                             sat_r, sat_nxt;
  logic [rsv_pkg::COL_W-1:0]        col_r, col_nxt;
  logic [rsv_pkg::SAMPLE_W-1:0]     x_r, x_nxt;
  logic                             last_r, last_nxt;
  logic [rsv_pkg::DELTA_W-1:0]      delta_r, delta_nxt;
  logic [rsv_pkg::M2_W-1:0]         var_r, var_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [rsv_pkg::COL_W-1:0]        out_col_r, out_col_nxt;
  logic [rsv_pkg::M2_W-1:0]         out_var_r, out_var_nxt;
  logic [rsv_pkg::COUNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic [rsv_pkg::STAT_W-1:0]       out_stat_r, out_stat_nxt;

  rsv_pkg::div_req_t                div_req;
  rsv_pkg::mul_req_t                mul_req;
  logic                             div_done, mul_done;
  logic [rsv_pkg::M2_W-1:0]         div_q, mul_p;

  logic                             in_xfer;
  logic [rsv_pkg::DELTA_W-1:0]      x_ext, mean_ext, delta_in, delta_mag;
  logic [rsv_pkg::DELTA_W-1:0]      q_s, mnew, resid, resid_mag;
  logic [rsv_pkg::M2_W:0]           m2_sum;

  rsv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  rsv_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_p)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    x_ext     = {in_sample_value[rsv_pkg::SAMPLE_W-1], in_sample_value};
    mean_ext  = {mean_r[rsv_pkg::SAMPLE_W-1], mean_r};
    delta_in  = x_ext - mean_ext;
    delta_mag = delta_r[rsv_pkg::DELTA_W-1] ? (~delta_r + 1'b1) : delta_r;
    q_s       = delta_r[rsv_pkg::DELTA_W-1] ? (~div_q[rsv_pkg::DELTA_W-1:0] + 1'b1)
                                            : div_q[rsv_pkg::DELTA_W-1:0];
    mnew      = mean_ext + q_s;
    resid     = {x_r[rsv_pkg::SAMPLE_W-1], x_r} - mean_ext;
    resid_mag = resid[rsv_pkg::DELTA_W-1] ? (~resid + 1'b1) : resid;
    m2_sum    = {1'b0, m2_r} + {1'b0, mul_p};
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    m2_nxt        = m2_r;
    sat_nxt       = sat_r;
    col_nxt       = col_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    delta_nxt     = delta_r;
    var_nxt       = var_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_col_nxt   = out_col_r;
    out_var_nxt   = out_var_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    div_req       = '0;
    mul_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          col_nxt  = in_column_index;
          x_nxt    = in_sample_value;
          last_nxt = in_last_sample;
          if (count_r >= rsv_pkg::MAX_SAMPLES) begin
            sat_nxt   = 1'b1;
            state_nxt = in_last_sample ? S_FIN : S_IDLE;
          end else begin
            count_nxt = count_r + 1'b1;
            delta_nxt = delta_in;
            state_nxt = S_DIV;
          end
        end
      end
      default: begin
      end
    endcase

    case (state_r)
      S_DIV: begin
        if (div_done) begin
          mean_nxt  = mnew[rsv_pkg::SAMPLE_W-1:0];
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = delta_mag;
        mul_req.mplier = resid_mag;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          if (m2_sum[rsv_pkg::M2_W]) begin
            m2_nxt  = '1;
            sat_nxt = 1'b1;
          end else begin
            m2_nxt = m2_sum[rsv_pkg::M2_W-1:0];
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (count_r < 16'd2) begin
          var_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.iters    = rsv_pkg::DIV_ITERS_VAR;
          div_req.dividend = m2_r;
          div_req.divisor  = count_r - 1'b1;
          state_nxt        = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          var_nxt   = div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r;
          out_var_nxt   = var_r;
          out_cnt_nxt   = count_r;
          if (count_r < 16'd2) begin
            out_stat_nxt = rsv_pkg::STAT_SHORT;
          end else if (sat_r) begin
            out_stat_nxt = rsv_pkg::STAT_SAT;
          end else begin
            out_stat_nxt = rsv_pkg::STAT_OK;
          end
          count_nxt = '0;
          mean_nxt  = '0;
          m2_nxt    = '0;
          sat_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
      end
    endcase

    if (state_r == S_IDLE && in_xfer && count_r < rsv_pkg::MAX_SAMPLES) begin
      div_req.start    = 1'b1;
      div_req.iters    = rsv_pkg::DIV_ITERS_MEAN;
      div_req.dividend = {delta_in[rsv_pkg::DELTA_W-1] ? (~delta_in + 1'b1) : delta_in,
                          {(rsv_pkg::M2_W-rsv_pkg::DELTA_W){1'b0}}};
      div_req.divisor  = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      m2_r        <= m2_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r      <= col_nxt;
    x_r        <= x_nxt;
    last_r     <= last_nxt;
    delta_r    <= delta_nxt;
    var_r      <= var_nxt;
    out_col_r  <= out_col_nxt;
    out_var_r  <= out_var_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_column = out_col_r;
  assign out_variance      = out_var_r;
  assign out_sample_count  = out_cnt_r;
  assign out_status        = out_stat_r;

endmodule
`default_nettype wire

>>> tb/rsv_checker.sv
`timescale 1ns / 100ps
// Checker for the running sample variance block: predicts each run's result and compares it.
module rsv_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [rsv_pkg::COL_W-1:0]           in_column_index,
  input  logic signed [rsv_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                in_last_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [rsv_pkg::COL_W-1:0]           out_result_column,
  input  logic [rsv_pkg::M2_W-1:0]            out_variance,
  input  logic [rsv_pkg::COUNT_W-1:0]         out_sample_count,
  input  logic [rsv_pkg::STAT_W-1:0]          out_status,
  output int unsigned                         err_count,
  output int unsigned                         pending_results
);
  import rsv_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [M2_W-1:0]    variance;
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } variance_result_t;

  logic [COUNT_W-1:0]         tally;
  logic signed [SAMPLE_W-1:0] mean_q16;
  logic [M2_W-1:0]            m2_acc;
  logic                       sat_run;
  variance_result_t           variance_expected_q[$];
  variance_result_t           want;

  task automatic clear_run();
    tally    = '0;
    mean_q16 = '0;
    m2_acc   = '0;
    sat_run  = 1'b0;
  endtask

  task automatic absorb_sample(input logic [COL_W-1:0] col,
                               input logic signed [SAMPLE_W-1:0] x,
                               input logic last);
    longint           n, mean, delta, moved, resid;
    logic [M2_W-1:0]  mag_delta, mag_resid, incr;
    logic [M2_W:0]    total;
    variance_result_t res;
    if (tally >= MAX_SAMPLES) begin
      sat_run = 1'b1;
    end else begin
      tally     = tally + 1'b1;
      n         = longint'(tally);
      mean      = longint'(mean_q16);
      delta     = longint'(x) - mean;
      moved     = mean + delta / n;
      resid     = longint'(x) - moved;
      mag_delta = (delta < 0) ? -delta : delta;
      mag_resid = (resid < 0) ? -resid : resid;
      incr      = mag_delta * mag_resid;
      total     = {1'b0, m2_acc} + {1'b0, incr};
      if (total[M2_W]) begin
        m2_acc  = '1;
        sat_run = 1'b1;
      end else begin
        m2_acc = total[M2_W-1:0];
      end
      mean_q16 = moved[SAMPLE_W-1:0];
    end
    if (last) begin
      res.column = col;
      res.count  = tally;
      if (tally < 2) begin
        res.variance = '0;
        res.status   = STAT_SHORT;
      end else begin
        res.variance = m2_acc / ({{(M2_W-COUNT_W){1'b0}}, tally} - 64'd1);
        res.status   = sat_run ? STAT_SAT : STAT_OK;
      end
      variance_expected_q.push_back(res);
      clear_run();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      variance_expected_q.delete();
      err_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (variance_expected_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result transfer: column %0d variance %h count %0d status %0d",
                   $time, out_result_column, out_variance, out_sample_count, out_status);
        end else begin
          want = variance_expected_q.pop_front();
          if (out_result_column !== want.column) begin
            err_count++;
            $display("%0t: column mismatch: expected %0d actual %0d",
                     $time, want.column, out_result_column);
          end
          if (out_variance !== want.variance) begin
            err_count++;
            $display("%0t: variance mismatch: expected %h actual %h",
                     $time, want.variance, out_variance);
          end
          if (out_sample_count !== want.count) begin
            err_count++;
            $display("%0t: count mismatch: expected %0d actual %0d",
                     $time, want.count, out_sample_count);
          end
          if (out_status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_status);
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_sample(in_column_index, in_sample_value, in_last_sample);
      end
    end
    pending_results <= variance_expected_q.size();
  end

endmodule

>>> tb/tb_running_sample_variance.sv
`timescale 1ns / 100ps
// Testbench top: drives sample runs into the running variance block and reports the verdict.
module tb_running_sample_variance;
  import rsv_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned IDLE_LIMIT   = 6000;
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef enum int {RX_FREE, RX_SPARSE, RX_TOGGLE, RX_COIN, RX_HOLD} rx_mode_t;
  typedef enum int {VAL_FULL, VAL_NEAR, VAL_EXTREME, VAL_FLAT} value_style_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [COL_W-1:0]           in_column_index;
  logic signed [SAMPLE_W-1:0] in_sample_value;
  logic                       in_last_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic [COL_W-1:0]           out_result_column;
  logic [M2_W-1:0]            out_variance;
  logic [COUNT_W-1:0]         out_sample_count;
  logic [STAT_W-1:0]          out_status;
  int unsigned                err_count;
  int unsigned                pending_results;
  int unsigned                idle_cycles;
  int                         burst_left;

  running_sample_variance u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_column_index   (in_column_index),
    .in_sample_value   (in_sample_value),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_column (out_result_column),
    .out_variance      (out_variance),
    .out_sample_count  (out_sample_count),
    .out_status        (out_status)
  );

  rsv_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_column_index   (in_column_index),
    .in_sample_value   (in_sample_value),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_column (out_result_column),
    .out_variance      (out_variance),
    .out_sample_count  (out_sample_count),
    .out_status        (out_status),
    .err_count         (err_count),
    .pending_results   (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : receiver
    rx_mode_t mode;
    int       span;
    out_ready = 1'b0;
    mode      = RX_FREE;
    span      = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 4));
        span = $urandom_range(20, 300);
      end
      span--;
      case (mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        RX_TOGGLE: out_ready <= ~out_ready;
        RX_HOLD:   out_ready <= 1'b0;
        default:   out_ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [COL_W-1:0] col, input logic [SAMPLE_W-1:0] value,
                             input logic last);
    int gap;
    in_valid        <= 1'b1;
    in_column_index <= col;
    in_sample_value <= value;
    in_last_sample  <= last;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_value(input value_style_t style,
                                                     input logic [SAMPLE_W-1:0] base);
    logic [SAMPLE_W-1:0] v;
    case (style)
      VAL_FULL: v = $urandom();
      VAL_NEAR: v = base + SAMPLE_W'($urandom_range(0, 4095)) - 32'd2048;
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = base;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int                  sent;
    int                  run_len;
    int                  k;
    bit                  pressed;
    logic [COL_W-1:0]    col;
    logic [SAMPLE_W-1:0] base;
    value_style_t        style;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_column_index = '0;
    in_sample_value = '0;
    in_last_sample  = 1'b0;
    burst_left      = $urandom_range(1, 12);
    pressed         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // one-sample runs at both ends of the column range, with zero and the most negative sample
    send_sample(10'd0, 32'h0000_0000, 1'b1);
    send_sample(10'd1023, 32'h8000_0000, 1'b1);
    // equal pair, then the widest pair
    send_sample(10'd3, 32'h7FFF_FFFF, 1'b0);
    send_sample(10'd3, 32'h7FFF_FFFF, 1'b1);
    send_sample(10'd4, 32'h8000_0000, 1'b0);
    send_sample(10'd4, 32'h7FFF_FFFF, 1'b1);
    // alternating extremes overflow M2
    for (k = 0; k < 8; k++) begin
      send_sample(10'd512, k[0] ? 32'h7FFF_FFFF : 32'h8000_0000, k == 7);
    end
    // mixed columns within one run
    send_sample(10'd5, 32'h0001_0000, 1'b0);
    send_sample(10'd6, 32'h0002_0000, 1'b0);
    send_sample(10'd7, 32'h0003_0000, 1'b1);
    // single-ulp spread
    send_sample(10'd341, 32'hFFFF_FFFF, 1'b0);
    send_sample(10'd341, 32'h0000_0001, 1'b0);
    send_sample(10'd682, 32'h0000_0000, 1'b1);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       run_len = 1;
        8:       run_len = $urandom_range(11, 40);
        default: run_len = $urandom_range(2, 10);
      endcase
      style = value_style_t'($urandom_range(0, 3));
      base  = $urandom();
      col   = COL_W'($urandom_range(0, 1023));
      for (k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 7) == 0) col = COL_W'($urandom_range(0, 1023));
        send_sample(col, pick_value(style, base), k == run_len - 1);
      end
      sent += run_len;
      if (!pressed && sent > RANDOM_ITEMS / 2) begin
        drain_results();
        pressed = 1'b1;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/rsv_pkg.sv
design/rsv_div.sv
design/rsv_mul.sv
design/running_sample_variance.sv
tb/rsv_checker.sv
tb/tb_running_sample_variance.sv
